// File: rtl/erlc_pkg.sv
package erlc_pkg;

    // Register indexes of the configuration port.
    localparam logic CFG_ESCAPE = 1'b0;
    localparam logic CFG_APPEND = 1'b1;

    localparam logic [7:0] ESCAPE_RESET  = 8'h60;
    localparam logic [7:0] MIN_CODED_RUN = 8'd4;
    localparam logic [7:0] MAX_RUN       = 8'd255;

    // Queue between the front and the back.
    localparam int JOB_DEPTH = 4;
    localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
    localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

    // Result queue inside the back.
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // Everything one input byte asks the back to write, in order:
    // the flushed old run, the escape triple, the run flushed at the end
    // of data and the end marker. Any part may be empty.
    typedef struct packed {
        logic [7:0] flush_value;
        logic [7:0] flush_length;
        logic       escape_triple;
        logic [7:0] tail_value;
        logic [7:0] tail_length;
        logic       end_marker;
    } job_t;

endpackage

// File: rtl/erlc_front.sv
module erlc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        data_byte,
    input  logic              end_of_data,
    input  logic [7:0]        escape_byte,
    input  logic              append_end_marker,
    output logic              job_push,
    output erlc_pkg::job_t    job
);

    logic [7:0] run_value_reg;
    logic [7:0] run_value_next;
    logic [7:0] run_length_reg;
    logic [7:0] run_length_next;

    logic       escape_hit;
    logic       extends_run;
    logic [7:0] grown_length;
    logic [7:0] after_value;
    logic [7:0] after_length;

    assign escape_hit   = (data_byte == escape_byte);
    assign extends_run  = !escape_hit && (run_length_reg != 8'd0)
                          && (data_byte == run_value_reg);
    assign grown_length = run_length_reg + 8'd1;

    always_comb
    begin
        job.flush_value   = run_value_reg;
        job.flush_length  = run_length_reg;
        job.escape_triple = 1'b0;
        after_value       = run_value_reg;
        after_length      = 8'd0;
        priority if (escape_hit)
        begin
            job.escape_triple = 1'b1;
        end
        else if (extends_run)
        begin
            if (grown_length == erlc_pkg::MAX_RUN)
            begin
                job.flush_length = grown_length;
            end
            else
            begin
                job.flush_length = 8'd0;
                after_length     = grown_length;
            end
        end
        else
        begin
            after_value  = data_byte;
            after_length = 8'd1;
        end
        job.tail_value  = after_value;
        job.tail_length = end_of_data ? after_length : 8'd0;
        job.end_marker  = end_of_data && append_end_marker;
    end

    assign job_push = accept && ((job.flush_length != 8'd0) || job.escape_triple
                                 || (job.tail_length != 8'd0) || job.end_marker);

    assign run_value_next  = accept ? after_value : run_value_reg;
    assign run_length_next = accept ? (end_of_data ? 8'd0 : after_length) : run_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_value_reg  <= 8'd0;
            run_length_reg <= 8'd0;
        end
        else
        begin
            run_value_reg  <= run_value_next;
            run_length_reg <= run_length_next;
        end
    end

endmodule

// File: rtl/erlc_job_queue.sv
module erlc_job_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  erlc_pkg::job_t    job_in,
    output logic              full,
    input  logic              pop,
    output erlc_pkg::job_t    job_out,
    output logic              empty
);

    erlc_pkg::job_t slots [erlc_pkg::JOB_DEPTH];

    logic [erlc_pkg::JOB_PTR_W-1:0] wr_ptr_reg;
    logic [erlc_pkg::JOB_PTR_W-1:0] wr_ptr_next;
    logic [erlc_pkg::JOB_PTR_W-1:0] rd_ptr_reg;
    logic [erlc_pkg::JOB_PTR_W-1:0] rd_ptr_next;
    logic [erlc_pkg::JOB_CNT_W-1:0] count_reg;
    logic [erlc_pkg::JOB_CNT_W-1:0] count_next;
    logic                           do_push;
    logic                           do_pop;

    assign full    = (count_reg == erlc_pkg::JOB_CNT_W'(erlc_pkg::JOB_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign job_out = slots[rd_ptr_reg];

    assign wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
    assign count_next  = count_reg + erlc_pkg::JOB_CNT_W'(do_push)
                         - erlc_pkg::JOB_CNT_W'(do_pop);

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= job_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/erlc_back.sv
module erlc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    input  erlc_pkg::job_t    job,
    input  logic [7:0]        escape_byte,
    output logic              job_pop,
    output logic              empty,
    input  logic              pop,
    output logic [7:0]        out_byte,
    output logic              out_last
);

    // Parts of a job, in the order they are written.
    localparam logic [1:0] SEG_FLUSH  = 2'd0;
    localparam logic [1:0] SEG_ESCAPE = 2'd1;
    localparam logic [1:0] SEG_TAIL   = 2'd2;
    localparam logic [1:0] SEG_MARKER = 2'd3;

    function automatic logic [1:0] run_count(input logic [7:0] len);
        return (len >= erlc_pkg::MIN_CODED_RUN) ? 2'd3 : len[1:0];
    endfunction

    function automatic logic [7:0] run_byte(input logic [7:0] len, input logic [7:0] value,
                                            input logic [1:0] pos, input logic [7:0] esc);
        logic [7:0] b;
        b = value;
        if (len >= erlc_pkg::MIN_CODED_RUN)
        begin
            if (pos == 2'd0)
            begin
                b = esc;
            end
            else if (pos == 2'd1)
            begin
                b = len;
            end
        end
        return b;
    endfunction

    logic [1:0] seg_reg;
    logic [1:0] seg_next;
    logic [1:0] pos_reg;
    logic [1:0] pos_next;

    logic [1:0] seg_count [4];
    logic [1:0] cur;
    logic       found;
    logic       more;
    logic       seg_done;
    logic       job_done;
    logic       emit;
    logic [7:0] emit_byte;

    // Result queue.
    logic [7:0] out_byte_mem [erlc_pkg::OUT_DEPTH];
    logic       out_last_mem [erlc_pkg::OUT_DEPTH];

    logic [erlc_pkg::OUT_PTR_W-1:0] wr_ptr_reg;
    logic [erlc_pkg::OUT_PTR_W-1:0] wr_ptr_next;
    logic [erlc_pkg::OUT_PTR_W-1:0] rd_ptr_reg;
    logic [erlc_pkg::OUT_PTR_W-1:0] rd_ptr_next;
    logic [erlc_pkg::OUT_CNT_W-1:0] count_reg;
    logic [erlc_pkg::OUT_CNT_W-1:0] count_next;
    logic                           out_full;
    logic                           do_pop;

    always_comb
    begin
        seg_count[SEG_FLUSH]  = run_count(job.flush_length);
        seg_count[SEG_ESCAPE] = job.escape_triple ? 2'd3 : 2'd0;
        seg_count[SEG_TAIL]   = run_count(job.tail_length);
        seg_count[SEG_MARKER] = job.end_marker ? 2'd3 : 2'd0;
    end

    // First non-empty part at or after the current one, and whether any follow.
    always_comb
    begin
        cur   = seg_reg;
        found = 1'b0;
        more  = 1'b0;
        for (int s = 0; s < 4; s++)
        begin
            if (!found && (2'(s) >= seg_reg) && (seg_count[s] != 2'd0))
            begin
                cur   = 2'(s);
                found = 1'b1;
            end
        end
        for (int s = 0; s < 4; s++)
        begin
            if ((2'(s) > cur) && (seg_count[s] != 2'd0))
            begin
                more = 1'b1;
            end
        end
    end

    always_comb
    begin
        unique case (cur)
            SEG_FLUSH:  emit_byte = run_byte(job.flush_length, job.flush_value, pos_reg,
                                             escape_byte);
            SEG_ESCAPE: emit_byte = (pos_reg == 2'd1) ? 8'd1 : escape_byte;
            SEG_TAIL:   emit_byte = run_byte(job.tail_length, job.tail_value, pos_reg,
                                             escape_byte);
            SEG_MARKER: emit_byte = (pos_reg == 2'd0) ? escape_byte : 8'd0;
            default:    emit_byte = escape_byte;
        endcase
    end

    assign out_full = (count_reg == erlc_pkg::OUT_CNT_W'(erlc_pkg::OUT_DEPTH));
    assign emit     = job_valid && !out_full;
    assign seg_done = (pos_reg == seg_count[cur] - 2'd1);
    assign job_done = seg_done && !more;
    assign job_pop  = emit && job_done;

    always_comb
    begin
        seg_next = seg_reg;
        pos_next = pos_reg;
        if (emit)
        begin
            if (job_done)
            begin
                seg_next = SEG_FLUSH;
                pos_next = 2'd0;
            end
            else if (seg_done)
            begin
                seg_next = cur + 2'd1;
                pos_next = 2'd0;
            end
            else
            begin
                seg_next = cur;
                pos_next = pos_reg + 2'd1;
            end
        end
    end

    assign do_pop      = pop && !empty;
    assign empty       = (count_reg == '0);
    assign out_byte    = out_byte_mem[rd_ptr_reg];
    assign out_last    = out_last_mem[rd_ptr_reg];
    assign wr_ptr_next = emit ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
    assign count_next  = count_reg + erlc_pkg::OUT_CNT_W'(emit)
                         - erlc_pkg::OUT_CNT_W'(do_pop);

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_mem[wr_ptr_reg] <= emit_byte;
            out_last_mem[wr_ptr_reg] <= job_done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg    <= SEG_FLUSH;
            pos_reg    <= 2'd0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            seg_reg    <= seg_next;
            pos_reg    <= pos_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/escaped_rle_compressor_core.sv
// Escape-byte run-length compressor. Raw bytes go in through a queue-like port (push/full),
// one per transaction, with end_of_data marking the last byte of a stream; compressed bytes
// come out through a second queue-like port (empty/pop), with out_last set on the final byte
// that each input byte causes. Runs of four or more equal bytes become escape, count, value;
// shorter runs are passed as literals, runs are cut at 255, and an escape byte in the data is
// written as escape, 1, escape. An input transaction is taken whenever the job queue between
// the classifying front and the writing back has room, and the back writes one compressed
// byte per cycle while its result queue has room. A byte that merely lengthens a run gives
// the back no work, and the worst item (a flushed run, an escape triple and an end marker)
// gives the back nine compressed bytes to write. The escape byte and end-marker flag may
// only be rewritten while the block is idle.
module escaped_rle_compressor_core (
    input  logic       clk,
    input  logic       rst_n,
    // Input queue side.
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       end_of_data,
    // Result queue side.
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       out_last,
    // Configuration writes.
    input  logic       cfg_write,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    // Configuration registers.
    logic [7:0] escape_reg;
    logic [7:0] escape_next;
    logic       append_reg;
    logic       append_next;

    // Front to back job queue.
    logic           accept;
    logic           job_push;
    logic           job_full;
    logic           job_empty;
    logic           job_pop;
    erlc_pkg::job_t front_job;
    erlc_pkg::job_t head_job;

    always_comb
    begin
        escape_next = escape_reg;
        append_next = append_reg;
        if (cfg_write)
        begin
            if (cfg_index == erlc_pkg::CFG_ESCAPE)
            begin
                escape_next = cfg_data;
            end
            else
            begin
                append_next = cfg_data[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_reg <= erlc_pkg::ESCAPE_RESET;
            append_reg <= 1'b0;
        end
        else
        begin
            escape_reg <= escape_next;
            append_reg <= append_next;
        end
    end

    // The front never stalls on its own; it only waits for room in the job queue, so a
    // transaction is taken whenever that queue is not full.
    assign full   = job_full;
    assign accept = push && !job_full;

    erlc_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .accept            (accept),
        .data_byte         (data_byte),
        .end_of_data       (end_of_data),
        .escape_byte       (escape_reg),
        .append_end_marker (append_reg),
        .job_push          (job_push),
        .job               (front_job)
    );

    // Items that produce no output (a byte that only lengthens a run) never enter the queue.
    erlc_job_queue u_job_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (job_push),
        .job_in  (front_job),
        .full    (job_full),
        .pop     (job_pop),
        .job_out (head_job),
        .empty   (job_empty)
    );

    // The back walks the job at the head of the queue into its result queue one byte per
    // cycle while that queue has room, and releases the job together with its last byte.
    erlc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (!job_empty),
        .job         (head_job),
        .escape_byte (escape_reg),
        .job_pop     (job_pop),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .out_last    (out_last)
    );

    // The back only releases a job that is actually waiting.
    assert property (@(posedge clk) disable iff (!rst_n) job_pop |-> !job_empty)
        else $error("job released from an empty job queue");

    // The front is stalled by full, so it can never push into a full job queue.
    assert property (@(posedge clk) disable iff (!rst_n) job_push |-> !job_full)
        else $error("job pushed into a full job queue");

    // An escape byte in the data always produces output, so a job must be waiting next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (accept && (data_byte == escape_reg)) |=> !job_empty)
        else $error("escape byte accepted without a job");

    // End of data with the end marker enabled always produces output.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (accept && end_of_data && append_reg) |=> !job_empty)
        else $error("end of data with end marker accepted without a job");

endmodule

// File: tb/escaped_rle_compressor_core_tb.sv
module escaped_rle_compressor_core_tb;

    // Cycles allowed after the last expected byte before the block counts as idle. Input bytes
    // that only lengthen a run are absorbed by the front and never reach the job queue, so
    // they produce nothing that could be waited for; the margin is a quiet gap before any
    // register write.
    localparam int SETTLE_CYCLES = 24;

    // One byte of the compressed stream together with its end-of-transaction flag.
    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } coded_byte_t;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [7:0] data_byte;
    logic       end_of_data;
    logic       empty;
    logic       pop;
    logic [7:0] out_byte;
    logic       out_last;
    logic       cfg_write;
    logic       cfg_index;
    logic [7:0] cfg_data;

    escaped_rle_compressor_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .data_byte   (data_byte),
        .end_of_data (end_of_data),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .out_last    (out_last),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // Our own copy of the compressor: the two registers and the pending run.
    logic [7:0] esc_reg;
    logic       marker_on;
    logic [7:0] run_val;
    logic [7:0] run_len;

    // Compressed bytes still owed by the block, oldest first, and the bytes that the
    // transaction currently being predicted gives rise to.
    coded_byte_t expected_stream[$];
    coded_byte_t step_bytes[$];

    int  error_count   = 0;
    int  items_sent    = 0;
    int  bytes_checked = 0;
    int  reg_writes    = 0;
    int  longest_burst = 0;
    bit  src_idle_on   = 1'b0;
    bit  sink_idle_on  = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Gap length for either side: mostly none or a few cycles, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic void emit_code(input logic [7:0] b);
        coded_byte_t c;
        c.code = b;
        c.last = 1'b0;
        step_bytes.push_back(c);
    endfunction

    function automatic void emit_triple(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
        emit_code(a);
        emit_code(b);
        emit_code(c);
    endfunction

    // Write out the pending run, as a coded triple if it is long enough and as literal
    // copies otherwise, and leave no run pending. The escape byte in force at the moment of
    // the flush is the one used, even if the run was begun under another.
    function automatic void flush_pending_run();
        if (run_len >= erlc_pkg::MIN_CODED_RUN)
        begin
            emit_triple(esc_reg, run_len, run_val);
        end
        else
        begin
            for (int k = 0; k < run_len; k++)
            begin
                emit_code(run_val);
            end
        end
        run_len = 8'd0;
    endfunction

    // Work out every compressed byte that one accepted input transaction causes and queue
    // them behind those still outstanding.
    function automatic void predict_compress(input logic [7:0] b, input logic eod);
        coded_byte_t tail;
        step_bytes.delete();
        if (b == esc_reg)
        begin
            // An escape byte in the data never joins a run.
            flush_pending_run();
            emit_triple(esc_reg, 8'd1, esc_reg);
        end
        else if (run_len != 8'd0 && b == run_val)
        begin
            run_len = run_len + 8'd1;
            if (run_len >= erlc_pkg::MAX_RUN)
            begin
                flush_pending_run();
            end
        end
        else
        begin
            flush_pending_run();
            run_val = b;
            run_len = 8'd1;
        end
        if (eod)
        begin
            flush_pending_run();
            if (marker_on)
            begin
                emit_triple(esc_reg, 8'd0, 8'd0);
            end
        end
        if (step_bytes.size() > 0)
        begin
            tail = step_bytes[step_bytes.size() - 1];
            tail.last = 1'b1;
            step_bytes[step_bytes.size() - 1] = tail;
        end
        if (step_bytes.size() > longest_burst)
        begin
            longest_burst = step_bytes.size();
        end
        foreach (step_bytes[i])
        begin
            expected_stream.push_back(step_bytes[i]);
        end
    endfunction

    // Present one raw byte and hold it until the block takes it. Push is left high on
    // return, so that a following byte with no gap goes straight in on the next cycle; the
    // next caller lowers it if it wants a gap.
    task automatic send_byte(input logic [7:0] b, input logic eod);
        int gap;
        gap = src_idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push        <= 1'b1;
        data_byte   <= b;
        end_of_data <= eod;
        do
        begin
            @(posedge clk);
        end
        while (full);
        predict_compress(b, eod);
        items_sent++;
    endtask

    // Stop sending and wait until every owed byte has come out, then give the block time to
    // finish any transactions that produce nothing.
    task automatic wait_quiet();
        push <= 1'b0;
        while (expected_stream.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write; the caller makes sure that the block is idle first.
    task automatic write_reg(input logic idx, input logic [7:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == erlc_pkg::CFG_ESCAPE)
        begin
            esc_reg = value;
        end
        else
        begin
            marker_on = value[0];
        end
        reg_writes++;
        @(posedge clk);
    endtask

    task automatic send_run(input logic [7:0] b, input int count, input logic eod_at_end);
        for (int k = 1; k <= count; k++)
        begin
            send_byte(b, eod_at_end && k == count);
        end
    endtask

    // A stream built from runs of two values, with escape bytes and arbitrary bytes mixed in.
    // Most runs are short, but about one in four is drawn at four to twelve bytes and coded.
    task automatic send_random_stream(input int len, input bit finish_stream);
        logic [7:0] val_a;
        logic [7:0] val_b;
        logic [7:0] pick;
        int         left;
        int         reps;
        int         r;
        val_a = 8'($urandom_range(0, 255));
        val_b = 8'($urandom_range(0, 255));
        left  = len;
        while (left > 0)
        begin
            r = $urandom_range(0, 99);
            if (r < 15)
            begin
                pick = esc_reg;
                reps = 1;
            end
            else if (r < 30)
            begin
                pick = 8'($urandom_range(0, 255));
                reps = 1;
            end
            else
            begin
                pick = r[0] ? val_a : val_b;
                reps = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12)
                                                   : $urandom_range(1, 5);
            end
            if (reps > left)
            begin
                reps = left;
            end
            repeat (reps)
            begin
                left--;
                send_byte(pick, finish_stream && left == 0);
            end
        end
    endtask

    // Literals, short and coded runs and escape bytes under the register values from reset.
    task automatic test_reset_settings();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        send_byte(8'h00, 1'b1);
        send_run(8'hFF, 3, 1'b1);
        send_run(8'hAA, 4, 1'b0);
        send_byte(8'h55, 1'b1);
        send_byte(erlc_pkg::ESCAPE_RESET, 1'b1);
        send_run(8'h12, 2, 1'b0);
        send_byte(erlc_pkg::ESCAPE_RESET, 1'b0);
        send_byte(8'h12, 1'b1);
        // A stream that ends, then a new one that must start from an empty run.
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);
        send_byte(8'h01, 1'b1);
    endtask

    // A run is cut as soon as it reaches 255, and the bytes after the cut begin a new run.
    task automatic test_run_limit();
        send_run(8'h3C, 257, 1'b1);
    endtask

    // Both registers at their extremes, the largest burst of output for one transaction, and
    // an escape byte rewritten while a run is pending.
    task automatic test_register_settings();
        wait_quiet();
        write_reg(erlc_pkg::CFG_ESCAPE, 8'h00);
        write_reg(erlc_pkg::CFG_APPEND, 8'd1);
        send_byte(8'h00, 1'b1);
        // Coded run, escape triple and end marker from one transaction.
        send_run(8'h7E, 4, 1'b0);
        send_byte(8'h00, 1'b1);

        wait_quiet();
        write_reg(erlc_pkg::CFG_ESCAPE, 8'hFF);
        send_run(8'hFF, 2, 1'b1);
        // Three literals, escape triple and end marker.
        send_run(8'h00, 3, 1'b0);
        send_byte(8'hFF, 1'b1);

        // The run of 0x41 is held over a change of escape to 0x41: it goes out as it stands,
        // coded under the new escape, and the next 0x41 is an escape byte of its own.
        wait_quiet();
        write_reg(erlc_pkg::CFG_APPEND, 8'd0);
        send_run(8'h41, 5, 1'b0);
        wait_quiet();
        write_reg(erlc_pkg::CFG_ESCAPE, 8'h41);
        send_byte(8'h41, 1'b0);
        send_run(8'h42, 2, 1'b0);
        wait_quiet();
        write_reg(erlc_pkg::CFG_ESCAPE, 8'h42);
        send_byte(8'h17, 1'b1);
    endtask

    // Random streams under four register settings. The first phase runs without gaps on
    // either side; in the second the sender stops once mid-stream until all owed bytes
    // have come out.
    task automatic test_random_streams();
        int start;
        bit drained;
        drained = 1'b0;
        for (int phase = 0; phase < 4; phase++)
        begin
            wait_quiet();
            unique case (phase)
                0:
                begin
                    src_idle_on  = 1'b0;
                    sink_idle_on = 1'b0;
                    write_reg(erlc_pkg::CFG_ESCAPE, 8'h00);
                    write_reg(erlc_pkg::CFG_APPEND, 8'd1);
                end
                1:
                begin
                    src_idle_on  = 1'b1;
                    sink_idle_on = 1'b1;
                    write_reg(erlc_pkg::CFG_ESCAPE, 8'hFF);
                    write_reg(erlc_pkg::CFG_APPEND, 8'd0);
                end
                2:
                begin
                    src_idle_on  = 1'b1;
                    sink_idle_on = 1'b0;
                    write_reg(erlc_pkg::CFG_ESCAPE, 8'($urandom_range(1, 254)));
                    write_reg(erlc_pkg::CFG_APPEND, 8'd1);
                end
                default:
                begin
                    src_idle_on  = 1'b0;
                    sink_idle_on = 1'b1;
                    write_reg(erlc_pkg::CFG_ESCAPE, erlc_pkg::ESCAPE_RESET);
                    write_reg(erlc_pkg::CFG_APPEND, 8'd0);
                end
            endcase
            start = items_sent;
            while (items_sent - start < 25)
            begin
                if (phase == 1 && !drained && items_sent - start > 8)
                begin
                    send_random_stream(4, 1'b0);
                    wait_quiet();
                    drained = 1'b1;
                end
                send_random_stream($urandom_range(1, 10), $urandom_range(0, 99) < 85);
            end
        end
    endtask

    // Result side: takes compressed bytes with random stalls and compares each one with the
    // oldest byte still owed.
    initial
    begin : result_checker
        coded_byte_t want;
        int          hold;
        hold = 0;
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                bytes_checked++;
                if (expected_stream.size() == 0)
                begin
                    $error("Compressed byte %02h (out_last %0b) arrived with nothing owed",
                           out_byte, out_last);
                    error_count++;
                end
                else
                begin
                    want = expected_stream.pop_front();
                    if (out_byte !== want.code)
                    begin
                        $error("out_byte: expected %02h, got %02h", want.code, out_byte);
                        error_count++;
                    end
                    if (out_last !== want.last)
                    begin
                        $error("out_last: expected %0b, got %0b", want.last, out_last);
                        error_count++;
                    end
                end
            end
            if (hold > 0)
            begin
                pop <= 1'b0;
                hold--;
            end
            else
            begin
                pop <= 1'b1;
                hold = sink_idle_on ? pick_gap() : 0;
            end
        end
    end

    initial
    begin : stimulus
        push        <= 1'b0;
        data_byte   <= 8'h00;
        end_of_data <= 1'b0;
        cfg_write   <= 1'b0;
        cfg_index   <= erlc_pkg::CFG_ESCAPE;
        cfg_data    <= 8'h00;
        rst_n       <= 1'b0;
        esc_reg   = erlc_pkg::ESCAPE_RESET;
        marker_on = 1'b0;
        run_val   = 8'h00;
        run_len   = 8'd0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_settings();
        test_run_limit();
        test_register_settings();
        test_random_streams();

        // Anything that turns up during the final wait has no expectation and is reported.
        wait_quiet();
        if (expected_stream.size() != 0)
        begin
            $error("%0d compressed bytes never arrived", expected_stream.size());
            error_count++;
        end
        $display("Sent %0d raw bytes and checked %0d compressed bytes over %0d register writes.",
                 items_sent, bytes_checked, reg_writes);
        $display("Runs up to the 255 cut, escapes, end markers; up to %0d bytes per transaction.",
                 longest_burst);
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Far beyond the slowest correct run, even with every long stall landing on every byte.
    initial
    begin : watchdog
        #10000000;
        $display("Timeout: the run did not finish in time.");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: escaped_rle_compressor_core.f
rtl/erlc_pkg.sv
rtl/erlc_front.sv
rtl/erlc_job_queue.sv
rtl/erlc_back.sv
rtl/escaped_rle_compressor_core.sv
tb/escaped_rle_compressor_core_tb.sv
